### rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is asserted
`define SCBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next
`define SCBA_ASSERT_NXT(lbl, ante, cons, msg) \
	`SCBA_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### rtl/scba_pkg.sv
// Package for the size-class block allocator: field widths, codes, reset values.
// No dependencies; imported by the allocator top level.
`default_nettype none

package scba_pkg;

	localparam int NUM_CLASSES = 4;
	localparam int CLS_W       = 2;
	localparam int LOG2_W      = 4;
	localparam int REQ_W       = 16;
	localparam int ADDR_W      = 20;
	// area base (up to 2^19) plus four regions of up to 64 x 4 KiB
	localparam int AREA_W      = ADDR_W + 1;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 24;

	typedef logic [LOG2_W-1:0] log2_t;

	localparam log2_t LOG2_MIN = 4'd3;
	localparam log2_t LOG2_MAX = 4'd12;
	localparam log2_t RESET_LOG2 [NUM_CLASSES] = '{4'd4, 4'd5, 4'd6, 4'd11};

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_BAD_FREE  = 2'd3
	} status_t;

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

endpackage

`default_nettype wire

### rtl/size_class_block_allocator_top.sv
// One item at a time: a new beat is taken only after the last one completes.
// The accept cycle reads the popped block's next pointer from the free-list memory;
// completion updates the class head and writes back (free pushes).
// A finished result waits in an output register while the next beat is taken.
// Reset and any register write rebuild all lists at once: per-entry written bits
// are cleared and unwritten entries read as the ascending chain; no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module size_class_block_allocator_top
	import scba_pkg::*;
#(
	parameter int HEADER_BYTES  = 8,
	parameter int BLOCKS_CLASS0 = 32,
	parameter int BLOCKS_CLASS1 = 32,
	parameter int BLOCKS_CLASS2 = 32,
	parameter int BLOCKS_CLASS3 = 16,
	parameter int AREA_BASE     = 0
)(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wen,
	input  wire logic [CLS_W-1:0]     cfg_addr,
	input  wire logic [LOG2_W-1:0]    cfg_wdata,
	input  wire logic                 s_tvalid,
	output      logic                 s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,   // request_size[15:0], block_address[35:16]
	input  wire logic                 s_tuser,   // action
	output      logic                 m_tvalid,
	input  wire logic                 m_tready,
	output      logic [M_TDATA_W-1:0] m_tdata    // status[1:0], granted_address[21:2]
);

	localparam int TOTAL = BLOCKS_CLASS0 + BLOCKS_CLASS1 + BLOCKS_CLASS2 + BLOCKS_CLASS3;
	localparam int IW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;

	localparam int COUNT [NUM_CLASSES] = '{BLOCKS_CLASS0, BLOCKS_CLASS1,
		BLOCKS_CLASS2, BLOCKS_CLASS3};
	localparam logic [IW-1:0] FIRST_IX [NUM_CLASSES] = '{IW'(0), IW'(BLOCKS_CLASS0),
		IW'(BLOCKS_CLASS0 + BLOCKS_CLASS1),
		IW'(BLOCKS_CLASS0 + BLOCKS_CLASS1 + BLOCKS_CLASS2)};
	localparam logic [IW-1:0] LAST_IX [NUM_CLASSES] = '{IW'(BLOCKS_CLASS0 - 1),
		IW'(BLOCKS_CLASS0 + BLOCKS_CLASS1 - 1),
		IW'(BLOCKS_CLASS0 + BLOCKS_CLASS1 + BLOCKS_CLASS2 - 1), IW'(TOTAL - 1)};

	// config and list heads
	log2_t             log2_q       [NUM_CLASSES];
	logic [IW-1:0]     class_head_q [NUM_CLASSES];
	logic [NUM_CLASSES-1:0] head_valid_q;
	logic [TOTAL-1:0]  written_q;

	// free-list memory: {valid, next index}
	logic [IW:0]       next_mem [TOTAL];
	logic [IW:0]       rd_s1;
	logic              rd_written_s1;

	// item in flight
	logic              busy_q;
	action_t           act_s1;
	logic [CLS_W-1:0]  cls_s1;
	status_t           err_s1;
	logic [IW-1:0]     idx_s1;
	logic [AREA_W-1:0] off_s1;

	// output register
	logic              m_tvalid_q;
	status_t           status_q;
	logic [ADDR_W-1:0] granted_q;

	// input side decode
	logic              acc;
	action_t           in_act;
	logic [REQ_W-1:0]  in_req;
	logic [ADDR_W-1:0] in_addr;
	logic [AREA_W-1:0] region_start [NUM_CLASSES+1];
	logic [REQ_W:0]    need;
	logic              alloc_hit;
	logic [CLS_W-1:0]  alloc_cls;
	logic [IW-1:0]     head_idx;
	logic              addr_ok;
	logic [AREA_W-1:0] rel;
	logic              free_hit;
	logic [CLS_W-1:0]  free_cls;
	logic [AREA_W-1:0] free_off;

	// completion side
	logic              done;
	logic              alloc_ok;
	logic              free_ok;
	logic              mem_we;
	logic              is_last;
	logic [IW:0]       next_val;
	logic [IW-1:0]     lcl;
	logic [AREA_W-1:0] blk_addr;
	logic [AREA_W-1:0] blk_mask;
	logic [AREA_W-1:0] free_lcl;
	logic [IW-1:0]     free_idx;
	status_t           status_d;

	assign acc      = s_tvalid && s_tready;
	assign s_tready = !busy_q;
	assign in_act   = action_t'(s_tuser);
	assign in_req   = s_tdata[REQ_W-1:0];
	assign in_addr  = s_tdata[REQ_W+ADDR_W-1:REQ_W];

	// region layout follows the block sizes
	always_comb begin
		region_start[0] = AREA_W'(AREA_BASE);
		for (int c = 0; c < NUM_CLASSES; c++)
			region_start[c+1] = region_start[c] + (AREA_W'(COUNT[c]) << log2_q[c]);
	end

	// allocate: first class whose payload holds the request
	assign need = {1'b0, in_req} + (REQ_W+1)'(HEADER_BYTES);
	always_comb begin
		alloc_hit = 1'b0;
		alloc_cls = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (need <= ((REQ_W+1)'(1) << log2_q[c])) begin
				alloc_hit = 1'b1;
				alloc_cls = CLS_W'(c);
			end
		end
	end
	assign head_idx = class_head_q[alloc_cls];

	// free: find the region holding the block start
	assign addr_ok = in_addr >= ADDR_W'(HEADER_BYTES);
	assign rel     = AREA_W'(in_addr) - AREA_W'(HEADER_BYTES);
	always_comb begin
		free_hit = 1'b0;
		free_cls = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (rel >= region_start[c] && rel < region_start[c+1]) begin
				free_hit = 1'b1;
				free_cls = CLS_W'(c);
			end
		end
	end
	assign free_off = rel - region_start[free_cls];

	// completion
	assign done = busy_q && (!m_tvalid_q || m_tready);

	always_comb begin
		is_last = 1'b0;
		for (int c = 0; c < NUM_CLASSES; c++)
			if (idx_s1 == LAST_IX[c])
				is_last = 1'b1;
	end
	assign next_val = rd_written_s1 ? rd_s1 : {!is_last, idx_s1 + IW'(1)};

	assign lcl      = idx_s1 - FIRST_IX[cls_s1];
	assign blk_addr = region_start[cls_s1] + (AREA_W'(lcl) << log2_q[cls_s1])
		+ AREA_W'(HEADER_BYTES);

	assign blk_mask = (AREA_W'(1) << log2_q[cls_s1]) - AREA_W'(1);
	assign free_lcl = off_s1 >> log2_q[cls_s1];
	assign free_idx = FIRST_IX[cls_s1] + free_lcl[IW-1:0];

	assign alloc_ok = (act_s1 == ACT_ALLOC) && (err_s1 == ST_OK) && head_valid_q[cls_s1];
	assign free_ok  = (act_s1 == ACT_FREE) && (err_s1 == ST_OK)
		&& ((off_s1 & blk_mask) == '0);
	assign mem_we   = done && free_ok;

	always_comb begin
		if (act_s1 == ACT_ALLOC) begin
			if (err_s1 != ST_OK)
				status_d = err_s1;
			else if (!head_valid_q[cls_s1])
				status_d = ST_EMPTY;
			else
				status_d = ST_OK;
		end else begin
			status_d = free_ok ? ST_OK : ST_BAD_FREE;
		end
	end

	// free-list memory: one read at accept, one write when a free completes
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1         <= next_mem[head_idx];
			rd_written_s1 <= written_q[head_idx];
		end
		if (mem_we)
			next_mem[free_idx] <= {head_valid_q[cls_s1], class_head_q[cls_s1]};
	end

	// item payload captured at accept, result captured at completion
	always_ff @(posedge clk) begin
		if (acc) begin
			act_s1 <= in_act;
			idx_s1 <= head_idx;
			off_s1 <= free_off;
			if (in_act == ACT_ALLOC) begin
				cls_s1 <= alloc_cls;
				err_s1 <= alloc_hit ? ST_OK : ST_TOO_LARGE;
			end else begin
				cls_s1 <= free_cls;
				err_s1 <= (addr_ok && free_hit) ? ST_OK : ST_BAD_FREE;
			end
		end
		if (done) begin
			status_q  <= status_d;
			granted_q <= alloc_ok ? blk_addr[ADDR_W-1:0] : '0;
		end
	end

	// control, config and list heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				log2_q[c]       <= RESET_LOG2[c];
				class_head_q[c] <= FIRST_IX[c];
			end
			head_valid_q <= '1;
			written_q    <= '0;
			busy_q       <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (acc)
				busy_q <= 1'b1;
			else if (done)
				busy_q <= 1'b0;

			if (done)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			// pop on allocate
			if (done && alloc_ok) begin
				class_head_q[cls_s1] <= next_val[IW-1:0];
				head_valid_q[cls_s1] <= next_val[IW];
			end
			// push on free
			if (mem_we) begin
				class_head_q[cls_s1] <= free_idx;
				head_valid_q[cls_s1] <= 1'b1;
				written_q[free_idx]  <= 1'b1;
			end

			// register write clamps the size and rebuilds every list
			if (cfg_wen) begin
				if (cfg_wdata < LOG2_MIN)
					log2_q[cfg_addr] <= LOG2_MIN;
				else if (cfg_wdata > LOG2_MAX)
					log2_q[cfg_addr] <= LOG2_MAX;
				else
					log2_q[cfg_addr] <= cfg_wdata;
				for (int c = 0; c < NUM_CLASSES; c++)
					class_head_q[c] <= FIRST_IX[c];
				head_valid_q <= '1;
				written_q    <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(M_TDATA_W-ADDR_W-2)'(0), granted_q, status_q};

	// checks
	`SCBA_ASSERT(a_fail_zero_addr, (m_tvalid && status_q != ST_OK) |-> (granted_q == '0), "failed result carries an address")
	`SCBA_ASSERT_NXT(a_done_to_out, done, (m_tvalid && !busy_q), "finished item did not reach the output register")
	`SCBA_ASSERT_NXT(a_free_at_head, mem_we, (head_valid_q[cls_s1] && class_head_q[cls_s1] == $past(free_idx)), "freed block is not the class head")

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the size-class block allocator: directed table plus
// random allocate/free traffic, checked against a free-list predictor.
// Depends on scba_pkg and size_class_block_allocator_top.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import scba_pkg::*;

	localparam int HDR         = 8;
	localparam int AREA_START  = 0;
	localparam int TOTAL_BLKS  = 112;
	localparam int CYCLE_LIMIT = 200000;
	localparam int BLK_CNT [NUM_CLASSES] = '{32, 32, 32, 16};

	// {class3, class2, class1, class0} size_log2 per phase; phase 0 keeps reset values
	localparam logic [15:0] PHASE_SIZES [6] = '{16'hB654, 16'hF210, 16'hCCCC,
		16'h6543, 16'hA937, 16'hB654};

	typedef struct packed {
		status_t            st;
		logic [ADDR_W-1:0]  ga;
	} grant_t;

	typedef struct packed {
		action_t            act;
		logic [REQ_W-1:0]   sz;
		logic [ADDR_W-1:0]  adr;
		logic [4:0]         reps;
		logic               typed;
		status_t            st;
		logic [ADDR_W-1:0]  ga;
	} dir_row_t;

	// Directed rows at reset sizes: region bases 0, 512, 1536, 3584
	localparam dir_row_t DIR_ROWS [24] = '{
		'{ACT_ALLOC, 16'd0,     20'd0,       5'd1,  1'b1, ST_OK,        20'd8},
		'{ACT_ALLOC, 16'd8,     20'd0,       5'd1,  1'b1, ST_OK,        20'd24},
		'{ACT_ALLOC, 16'd9,     20'd0,       5'd1,  1'b1, ST_OK,        20'd520},
		'{ACT_ALLOC, 16'd24,    20'd0,       5'd1,  1'b1, ST_OK,        20'd552},
		'{ACT_ALLOC, 16'd25,    20'd0,       5'd1,  1'b1, ST_OK,        20'd1544},
		'{ACT_ALLOC, 16'd2040,  20'd0,       5'd1,  1'b1, ST_OK,        20'd3592},
		'{ACT_ALLOC, 16'd2041,  20'd0,       5'd1,  1'b1, ST_TOO_LARGE, 20'd0},
		'{ACT_ALLOC, 16'hFFFF,  20'd0,       5'd1,  1'b1, ST_TOO_LARGE, 20'd0},
		'{ACT_FREE,  16'd0,     20'd8,       5'd1,  1'b1, ST_OK,        20'd0},
		'{ACT_ALLOC, 16'd1,     20'd0,       5'd1,  1'b1, ST_OK,        20'd8},
		'{ACT_FREE,  16'd0,     20'd0,       5'd1,  1'b1, ST_BAD_FREE,  20'd0},
		'{ACT_FREE,  16'd0,     20'd7,       5'd1,  1'b1, ST_BAD_FREE,  20'd0},
		'{ACT_FREE,  16'd0,     20'd9,       5'd1,  1'b1, ST_BAD_FREE,  20'd0},
		'{ACT_FREE,  16'd0,     20'hFFFFF,   5'd1,  1'b1, ST_BAD_FREE,  20'd0},
		'{ACT_FREE,  16'd0,     20'd36360,   5'd1,  1'b1, ST_BAD_FREE,  20'd0},
		'{ACT_FREE,  16'd0,     20'd552,     5'd1,  1'b1, ST_OK,        20'd0},
		// same block again: pushed twice
		'{ACT_FREE,  16'd0,     20'd552,     5'd1,  1'b1, ST_OK,        20'd0},
		'{ACT_ALLOC, 16'd20,    20'hFFFFF,   5'd1,  1'b0, ST_OK,        20'd0},
		'{ACT_ALLOC, 16'd20,    20'd0,       5'd1,  1'b0, ST_OK,        20'd0},
		// drain the largest class, then hit it empty
		'{ACT_ALLOC, 16'd2000,  20'd0,       5'd15, 1'b0, ST_OK,        20'd0},
		'{ACT_ALLOC, 16'd57,    20'd0,       5'd1,  1'b1, ST_EMPTY,     20'd0},
		'{ACT_FREE,  16'd0,     20'd3592,    5'd1,  1'b1, ST_OK,        20'd0},
		'{ACT_ALLOC, 16'd2040,  20'd0,       5'd1,  1'b1, ST_OK,        20'd3592},
		'{ACT_FREE,  16'hFFFF,  20'd24,      5'd1,  1'b1, ST_OK,        20'd0}
	};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_wen   = 1'b0;
	logic [CLS_W-1:0]     cfg_addr  = '0;
	logic [LOG2_W-1:0]    cfg_wdata = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic                 s_tuser   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	// Predictor state: sizes and per-class LIFO free lists
	log2_t      cls_log2  [NUM_CLASSES];
	logic [6:0] head      [NUM_CLASSES];
	bit         head_ok   [NUM_CLASSES];
	logic [6:0] nxt       [TOTAL_BLKS];
	bit         nxt_ok    [TOTAL_BLKS];

	grant_t            pending_grants [$];
	logic [ADDR_W-1:0] live_addrs [$];
	logic [ADDR_W-1:0] last_freed = '0;
	bit                have_freed = 1'b0;
	int                src_idle_pct = 0;
	int                snk_idle_pct = 0;
	int                mismatches   = 0;
	int                cycle_cnt    = 0;

	size_class_block_allocator_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // request_size[15:0], block_address[35:16]
		.s_tuser   (s_tuser),   // action
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)    // status[1:0], granted_address[21:2]
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int first_blk(int c);
		int s = 0;
		for (int k = 0; k < c; k++) s += BLK_CNT[k];
		return s;
	endfunction

	function automatic longint region_base(int c);
		longint a = AREA_START;
		for (int k = 0; k < c; k++) a += longint'(BLK_CNT[k]) << cls_log2[k];
		return a;
	endfunction

	// Ascending chain per class, last entry terminates
	function automatic void rebuild_lists();
		int b = 0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			head[c]    = 7'(b);
			head_ok[c] = 1'b1;
			for (int i = 0; i < BLK_CNT[c]; i++) begin
				nxt_ok[b+i] = (i + 1 < BLK_CNT[c]);
				nxt[b+i]    = nxt_ok[b+i] ? 7'(b + i + 1) : 7'd0;
			end
			b += BLK_CNT[c];
		end
	endfunction

	// Pop or push one block and return the grant it yields
	function automatic grant_t predict_grant(action_t act, logic [REQ_W-1:0] sz,
			logic [ADDR_W-1:0] adr);
		grant_t g;
		longint bytes, start, off, a;
		int idx;
		g.st = ST_OK;
		g.ga = '0;
		if (act == ACT_ALLOC) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				bytes = longint'(1) << cls_log2[c];
				if (bytes < HDR || longint'(sz) > bytes - HDR) continue;
				if (!head_ok[c]) begin
					g.st = ST_EMPTY;
					return g;
				end
				idx        = head[c];
				head_ok[c] = nxt_ok[idx];
				head[c]    = nxt[idx];
				g.ga = 20'(region_base(c) + (longint'(idx - first_blk(c)) << cls_log2[c]) + HDR);
				return g;
			end
			g.st = ST_TOO_LARGE;
			return g;
		end
		g.st = ST_BAD_FREE;
		if (adr < HDR) return g;
		a = longint'(adr) - HDR;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			start = region_base(c);
			bytes = longint'(1) << cls_log2[c];
			if (a < start || a >= start + BLK_CNT[c] * bytes) continue;
			off = a - start;
			if ((off & (bytes - 1)) != 0) return g;
			idx        = first_blk(c) + int'(off >> cls_log2[c]);
			nxt[idx]    = head[c];
			nxt_ok[idx] = head_ok[c];
			head[c]     = 7'(idx);
			head_ok[c]  = 1'b1;
			g.st = ST_OK;
			return g;
		end
		return g;
	endfunction

	// One request beat: optional idle cycles, then hold until accepted
	task automatic send_beat(input action_t act, input logic [REQ_W-1:0] sz,
			input logic [ADDR_W-1:0] adr, input bit typed, input status_t t_st,
			input logic [ADDR_W-1:0] t_ga);
		grant_t pred;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {4'b0, adr, sz};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pred = predict_grant(act, sz, adr);
		if (act == ACT_ALLOC && pred.st == ST_OK) live_addrs.push_back(pred.ga);
		if (typed) begin
			pred.st = t_st;
			pred.ga = t_ga;
		end
		pending_grants.push_back(pred);
	endtask

	// Mostly well-formed alloc/free traffic with some noise
	task automatic run_random(input int n);
		int r, c, p, j;
		action_t act;
		logic [REQ_W-1:0] sz;
		logic [ADDR_W-1:0] adr;
		repeat (n) begin
			r   = $urandom_range(0, 99);
			act = ACT_ALLOC;
			sz  = REQ_W'($urandom_range(0, 65535));
			adr = ADDR_W'($urandom_range(0, 20'hFFFFF));
			if (r < 50 || (r < 88 && live_addrs.size() == 0)) begin
				// aim at one class: anywhere in it, its top, just past it, or zero
				c = $urandom_range(0, NUM_CLASSES - 1);
				p = (1 << cls_log2[c]) - HDR;
				case ($urandom_range(0, 3))
					0: sz = REQ_W'($urandom_range(0, p));
					1: sz = REQ_W'(p);
					2: sz = REQ_W'(p + 1);
					default: sz = '0;
				endcase
			end else if (r < 55) begin
				act = ACT_ALLOC;
			end else if (r < 88) begin
				act = ACT_FREE;
				j   = $urandom_range(0, live_addrs.size() - 1);
				adr = live_addrs[j];
				live_addrs.delete(j);
				last_freed = adr;
				have_freed = 1'b1;
			end else if (r < 92 && have_freed) begin
				act = ACT_FREE;
				adr = last_freed;
			end else begin
				act = ACT_FREE;
				if (live_addrs.size() != 0 && $urandom_range(0, 1) == 1)
					adr = live_addrs[$urandom_range(0, live_addrs.size() - 1)] +
						ADDR_W'($urandom_range(1, 7));
			end
			send_beat(act, sz, adr, 1'b0, ST_OK, '0);
		end
	endtask

	// Register writes, only with the pipeline empty
	task automatic write_sizes(input logic [15:0] vals);
		log2_t v;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		for (int c = 0; c < NUM_CLASSES; c++) begin
			v         = vals[4*c +: 4];
			cfg_wen   <= 1'b1;
			cfg_addr  <= CLS_W'(c);
			cfg_wdata <= v;
			cls_log2[c] = (v < LOG2_MIN) ? LOG2_MIN : (v > LOG2_MAX) ? LOG2_MAX : v;
			rebuild_lists();
			@(posedge clk);
		end
		cfg_wen <= 1'b0;
		live_addrs.delete();
		have_freed = 1'b0;
	endtask

	// Result sink stall pattern
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
	end

	// Result checker
	always @(posedge clk) begin
		grant_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_grants.size() == 0) begin
				$display("%0t: unexpected beat, status %0d address %h", $time,
					m_tdata[1:0], m_tdata[21:2]);
				mismatches++;
			end else begin
				want = pending_grants.pop_front();
				if (m_tdata[1:0] !== want.st) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.st, m_tdata[1:0]);
					mismatches++;
				end
				if (m_tdata[21:2] !== want.ga) begin
					$display("%0t: granted_address expected %h actual %h", $time,
						want.ga, m_tdata[21:2]);
					mismatches++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		for (int c = 0; c < NUM_CLASSES; c++) cls_log2[c] = RESET_LOG2[c];
		rebuild_lists();
		src_idle_pct = 30;
		snk_idle_pct = 69;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[i])
			repeat (DIR_ROWS[i].reps)
				send_beat(DIR_ROWS[i].act, DIR_ROWS[i].sz, DIR_ROWS[i].adr,
					DIR_ROWS[i].typed, DIR_ROWS[i].st, DIR_ROWS[i].ga);
		run_random(150);

		for (int ph = 1; ph < 6; ph++) begin
			s_tvalid <= 1'b0;
			if (ph == 2) begin
				src_idle_pct = 69;
				snk_idle_pct = 30;
			end else if (ph == 4) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			write_sizes(PHASE_SIZES[ph]);
			run_random(150);
		end

		s_tvalid <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

### size_class_block_allocator_top.f
+incdir+rtl
rtl/scba_pkg.sv
rtl/size_class_block_allocator_top.sv
tb/sv/testbench.sv
